// ===== src/dtvs_pkg.sv =====
`default_nettype none

package dtvs_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = 6;   // fixed width of the stack_depth field
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned TAG_W       = 2;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [2:0] {
    KIND_SET   = 3'd0,
    KIND_PUSH  = 3'd1,
    KIND_POP   = 3'd2,
    KIND_FLUSH = 3'd3,
    KIND_MARK  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET,
    OP_PUSH,
    OP_POP,
    OP_FLUSH,
    OP_MARK
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MODE     = 3'd1,
    ST_LOCKED   = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_MISMATCH = 3'd6,
    ST_NOTDIRTY = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_STACK_MODE  = 2'd0,
    CFG_ALLOW_DUPS  = 2'd1,
    CFG_IGNORE_DUPS = 2'd2,
    CFG_DIRTY_WRITE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    B_EXEC,
    B_REFILL
  } bstate_e;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
  } value_t;

  typedef struct packed {
    op_e    op;
    value_t value;
  } req_t;

  typedef struct packed {
    logic stack_mode;
    logic allow_dups;
    logic ignore_dups;
    logic dirty_write;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/dtvs_front.sv =====
`default_nettype none

module dtvs_front (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [2:0]                          kind_i,
  input  wire  [dtvs_pkg::TAG_W-1:0]          value_tag_i,
  input  wire  [dtvs_pkg::PAYLOAD_W-1:0]      value_payload_i,
  output logic                                q_valid_o,
  output dtvs_pkg::req_t                      q_req_o,
  input  wire                                 q_pop_i
);

  dtvs_pkg::req_t                    q_mem_q [dtvs_pkg::QUEUE_DEPTH];
  logic [dtvs_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [dtvs_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [dtvs_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  dtvs_pkg::req_t                    req;
  logic                              push;

  // classify: decode the kind, force null operands to payload zero
  always_comb begin
    req.value.tag     = value_tag_i;
    req.value.payload = (value_tag_i == '0) ? '0 : value_payload_i;
    case (kind_i)
      dtvs_pkg::KIND_SET:   req.op = dtvs_pkg::OP_SET;
      dtvs_pkg::KIND_PUSH:  req.op = dtvs_pkg::OP_PUSH;
      dtvs_pkg::KIND_POP:   req.op = dtvs_pkg::OP_POP;
      dtvs_pkg::KIND_FLUSH: req.op = dtvs_pkg::OP_FLUSH;
      dtvs_pkg::KIND_MARK:  req.op = dtvs_pkg::OP_MARK;
      default:              req.op = dtvs_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == dtvs_pkg::QCNT_W'(dtvs_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + dtvs_pkg::QCNT_W'(push) - dtvs_pkg::QCNT_W'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= req;
    end
  end

endmodule

`default_nettype wire

// ===== src/dtvs_back.sv =====
`default_nettype none

module dtvs_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  dtvs_pkg::cfg_t                      cfg_i,
  input  wire                                 q_valid_i,
  input  dtvs_pkg::req_t                      q_req_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [2:0]                          status_o,
  output logic                                duplicate_ignored_o,
  output logic                                newly_dirty_o,
  output logic                                dirty_now_o,
  output logic [dtvs_pkg::TAG_W-1:0]          current_tag_o,
  output logic [dtvs_pkg::PAYLOAD_W-1:0]      current_payload_o,
  output logic [dtvs_pkg::CNT_W-1:0]          stack_depth_o
);

  dtvs_pkg::bstate_e              state_q, state_d;

  dtvs_pkg::value_t               mem_q [dtvs_pkg::STACK_DEPTH];
  dtvs_pkg::value_t               rd_data_q;
  logic [dtvs_pkg::ADDR_W-1:0]    rd_addr;
  logic                           mem_we;

  logic                           dirty_q, dirty_d;
  dtvs_pkg::value_t               single_q, single_d;
  dtvs_pkg::value_t               flushed_q, flushed_d;
  dtvs_pkg::value_t               top_q, top_d;
  logic [dtvs_pkg::CNT_W-1:0]     count_q, count_d;
  logic                           pend_newly_q, pend_newly_d;

  logic                           take, pop_ok, out_load, locked, want_stack;
  dtvs_pkg::status_e              status;
  logic                           dup_ign, newly;
  dtvs_pkg::value_t               cur_q, cur_d;

  logic                           out_valid_q;
  logic [2:0]                     out_status_q;
  logic                           out_dup_q, out_newly_q, out_dirty_q;
  dtvs_pkg::value_t               out_cur_q;
  logic [dtvs_pkg::CNT_W-1:0]     out_depth_q;

  function automatic dtvs_pkg::value_t view(input logic mode,
                                            input logic [dtvs_pkg::CNT_W-1:0] cnt,
                                            input dtvs_pkg::value_t top,
                                            input dtvs_pkg::value_t single);
    dtvs_pkg::value_t v;
    if (!mode) begin
      v = single;
    end else if (cnt != '0) begin
      v = top;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // the output slot is free when empty or being drained this cycle
  assign take    = (state_q == dtvs_pkg::B_EXEC) && q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = take;
  assign locked  = dirty_q && !cfg_i.dirty_write;
  assign cur_q   = view(cfg_i.stack_mode, count_q, top_q, single_q);
  assign rd_addr = dtvs_pkg::ADDR_W'(count_q - dtvs_pkg::CNT_W'(2));

  // next state
  always_comb begin
    case (state_q)
      dtvs_pkg::B_EXEC:   state_d = pop_ok ? dtvs_pkg::B_REFILL : dtvs_pkg::B_EXEC;
      dtvs_pkg::B_REFILL: state_d = dtvs_pkg::B_EXEC;
      default:            state_d = dtvs_pkg::B_EXEC;
    endcase
  end

  // execute one request
  always_comb begin
    status       = dtvs_pkg::ST_OK;
    dup_ign      = 1'b0;
    newly        = 1'b0;
    pop_ok       = 1'b0;
    mem_we       = 1'b0;
    want_stack   = (q_req_i.op != dtvs_pkg::OP_SET);
    dirty_d      = dirty_q;
    single_d     = single_q;
    flushed_d    = flushed_q;
    top_d        = top_q;
    count_d      = count_q;
    pend_newly_d = pend_newly_q;
    out_load     = 1'b0;
    case (state_q)
      dtvs_pkg::B_REFILL: begin
        top_d    = rd_data_q;
        newly    = pend_newly_q;
        out_load = 1'b1;
      end
      dtvs_pkg::B_EXEC: begin
        if (take) begin
          out_load = 1'b1;
          case (q_req_i.op)
            dtvs_pkg::OP_SET, dtvs_pkg::OP_PUSH, dtvs_pkg::OP_POP: begin
              if (cfg_i.stack_mode != want_stack) begin
                status = dtvs_pkg::ST_MODE;
              end else if (locked) begin
                status = dtvs_pkg::ST_LOCKED;
              end else if (q_req_i.op == dtvs_pkg::OP_POP) begin
                if (count_q == '0) begin
                  status = dtvs_pkg::ST_EMPTY;
                end else if (top_q != q_req_i.value) begin
                  status = dtvs_pkg::ST_MISMATCH;
                end else begin
                  // result waits for the new top to come out of the stack memory
                  pop_ok       = 1'b1;
                  out_load     = 1'b0;
                  count_d      = count_q - 1'b1;
                  dirty_d      = 1'b1;
                  pend_newly_d = !dirty_q;
                end
              end else if (!cfg_i.allow_dups && (flushed_q == q_req_i.value)) begin
                if (cfg_i.ignore_dups) begin
                  dup_ign = 1'b1;
                end else begin
                  status = dtvs_pkg::ST_DUP;
                end
              end else if (q_req_i.op == dtvs_pkg::OP_SET) begin
                single_d = q_req_i.value;
                dirty_d  = 1'b1;
                newly    = !dirty_q;
              end else if (count_q >= dtvs_pkg::CNT_W'(dtvs_pkg::STACK_DEPTH)) begin
                status = dtvs_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                top_d   = q_req_i.value;
                count_d = count_q + 1'b1;
                dirty_d = 1'b1;
                newly   = !dirty_q;
              end
            end
            dtvs_pkg::OP_FLUSH: begin
              if (!dirty_q) begin
                status = dtvs_pkg::ST_NOTDIRTY;
              end else begin
                flushed_d = cur_q;
                dirty_d   = 1'b0;
              end
            end
            dtvs_pkg::OP_MARK: begin
              dirty_d = 1'b1;
              newly   = !dirty_q;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign cur_d = view(cfg_i.stack_mode, count_d, top_d, single_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dtvs_pkg::B_EXEC;
      dirty_q      <= 1'b0;
      single_q     <= '0;
      flushed_q    <= '0;
      count_q      <= '0;
      pend_newly_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dirty_q      <= dirty_d;
      single_q     <= single_d;
      flushed_q    <= flushed_d;
      count_q      <= count_d;
      pend_newly_q <= pend_newly_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (out_load) begin
      out_status_q <= status;
      out_dup_q    <= dup_ign;
      out_newly_q  <= newly;
      out_dirty_q  <= dirty_d;
      out_cur_q    <= cur_d;
      out_depth_q  <= count_d;
    end
  end

  // stack storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[dtvs_pkg::ADDR_W-1:0]] <= q_req_i.value;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign duplicate_ignored_o = out_dup_q;
  assign newly_dirty_o       = out_newly_q;
  assign dirty_now_o         = out_dirty_q;
  assign current_tag_o       = out_cur_q.tag;
  assign current_payload_o   = out_cur_q.payload;
  assign stack_depth_o       = out_depth_q;

endmodule

`default_nettype wire

// ===== src/dirty_tracked_value_stack_top.sv =====
// dirty-tracked value channel: holds one value (single mode) or a stack of up to
// 32 values (stack mode), plus a dirty mark and the value captured at the last
// flush. each request is set, push, pop with expected top, flush or mark dirty,
// and produces exactly one response carrying a status code, the duplicate-ignored
// and newly-dirty flags, the dirty mark and the visible value and stack depth.
// a front stage classifies requests into a two-entry queue; the back stage runs
// them one at a time. a successful pop needs an extra refill step in the back
// stage, in which it takes no new request, because the new stack top is fetched
// from the stack memory, whose read data is registered. a request passes from the
// queue to the back stage once that is free, and its response is registered in the
// output register, for a successful pop after the refill step. while a response is
// stalled the back stage waits and the queue takes up to two more requests.
// configuration writes are always ready and take effect on the next cycle; write
// them only while no request is in flight
`default_nettype none

module dirty_tracked_value_stack_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration writes
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [1:0]                          cfg_index_i,
  input  wire                                 cfg_data_i,
  // request channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [2:0]                          kind_i,
  input  wire  [dtvs_pkg::TAG_W-1:0]          value_tag_i,
  input  wire  [dtvs_pkg::PAYLOAD_W-1:0]      value_payload_i,
  // response channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [2:0]                          status_o,
  output logic                                duplicate_ignored_o,
  output logic                                newly_dirty_o,
  output logic                                dirty_now_o,
  output logic [dtvs_pkg::TAG_W-1:0]          current_tag_o,
  output logic [dtvs_pkg::PAYLOAD_W-1:0]      current_payload_o,
  output logic [dtvs_pkg::CNT_W-1:0]          stack_depth_o
);

  dtvs_pkg::cfg_t  cfg_q, cfg_d;
  logic            q_valid;
  logic            q_pop;
  dtvs_pkg::req_t  q_req;

  // configuration registers, never busy
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dtvs_pkg::CFG_STACK_MODE:  cfg_d.stack_mode  = cfg_data_i;
        dtvs_pkg::CFG_ALLOW_DUPS:  cfg_d.allow_dups  = cfg_data_i;
        dtvs_pkg::CFG_IGNORE_DUPS: cfg_d.ignore_dups = cfg_data_i;
        dtvs_pkg::CFG_DIRTY_WRITE: cfg_d.dirty_write = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: decode and queue requests
  dtvs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .value_tag_i    (value_tag_i),
    .value_payload_i(value_payload_i),
    .q_valid_o      (q_valid),
    .q_req_o        (q_req),
    .q_pop_i        (q_pop)
  );

  // back: checks, state update, stack memory and response register
  dtvs_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_req_i            (q_req),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .duplicate_ignored_o(duplicate_ignored_o),
    .newly_dirty_o      (newly_dirty_o),
    .dirty_now_o        (dirty_now_o),
    .current_tag_o      (current_tag_o),
    .current_payload_o  (current_payload_o),
    .stack_depth_o      (stack_depth_o)
  );

`ifndef NO_ASSERTIONS
  // stack never reported deeper than its storage
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stack_depth_o <= dtvs_pkg::CNT_W'(dtvs_pkg::STACK_DEPTH)))
    else $error("stack depth beyond storage");

  // newly dirty only on a successful step that leaves the mark set
  a_newly_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && newly_dirty_o) |-> (dirty_now_o && status_o == dtvs_pkg::ST_OK))
    else $error("newly dirty without ok status and dirty mark");

  // an ignored duplicate changes nothing
  a_dup_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && duplicate_ignored_o) |->
      (status_o == dtvs_pkg::ST_OK && !newly_dirty_o))
    else $error("ignored duplicate with side effects");

  // a flush on a clean channel leaves it clean
  a_not_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dtvs_pkg::ST_NOTDIRTY) |-> !dirty_now_o)
    else $error("not-dirty status with dirty mark set");
`endif

endmodule

`default_nettype wire
